FILE: rtl/tmlr_pkg.sv
// ----------------------------------------------------------------------------
// tmlr_pkg: shared types and constants of the text-mode line renderer
// Store geometry, function codes and the command word that passes from the
// front end through the command queue to the back end.
// ----------------------------------------------------------------------------
package tmlr_pkg;

  // screen geometry in character cells
  localparam int COLUMNS = 40;
  localparam int ROWS    = 24;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int LINES   = ROWS * 8;

  // store address widths
  localparam int TXT_AW     = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int FONT_DEPTH = 2048;
  localparam int FONT_AW    = 11;
  localparam int COL_W      = $clog2(COLUMNS + 1);

  // reset value of the top line register
  localparam logic [7:0] TOP_LINE_RST = 8'd20;

  // depth of the command queue and of the result buffer
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // function codes of an input transaction
  localparam logic [1:0] FUNC_CHAR = 2'd0;
  localparam logic [1:0] FUNC_FONT = 2'd1;
  localparam logic [1:0] FUNC_LINE = 2'd2;

  typedef enum logic [1:0] {
    CMD_CHAR,
    CMD_FONT,
    CMD_LINE
  } cmd_kind_e;

  // addr: cell index, font byte index or first cell of the text row
  typedef struct packed {
    cmd_kind_e           kind;
    logic [FONT_AW-1:0]  addr;
    logic [7:0]          data;
    logic [2:0]          glyph;
  } cmd_t;

endpackage

FILE: rtl/tmlr_if.sv
// ----------------------------------------------------------------------------
// tmlr_if: channel interfaces of the text-mode line renderer
// Input item channel, result channel and configuration write channel, each
// with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tmlr_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [10:0] address;
  logic [7:0]  data;
  logic [7:0]  line;

  modport source (output valid, output func, output address, output data,
                  output line, input ready);
  modport sink   (input valid, input func, input address, input data,
                  input line, output ready);
endinterface

interface tmlr_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixels;
  logic       last;

  modport source (output valid, output pixels, output last, input ready);
  modport sink   (input valid, input pixels, input last, output ready);
endinterface

interface tmlr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/tmlr_ram.sv
// ----------------------------------------------------------------------------
// tmlr_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered. A read and a
// write of the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module tmlr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/tmlr_front.sv
// ----------------------------------------------------------------------------
// tmlr_front: input front end
// Holds the top line register, accepts input transactions and turns them
// into commands; out-of-range writes, invisible lines and unused function codes are dropped here.
// ----------------------------------------------------------------------------
module tmlr_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tmlr_item_if.sink            item_i,
  tmlr_cfg_if.sink             cfg_i,
  input  logic                 init_done_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output tmlr_pkg::cmd_t       q_cmd_o
);

  logic [7:0] top_line_q;
  logic [8:0] line_ofs;
  logic [4:0] row;
  logic       keep;

  // configuration register, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_line_q <= tmlr_pkg::TOP_LINE_RST;
    end else if (cfg_i.valid) begin
      top_line_q <= cfg_i.data;
    end
  end

  // position of the scan line within the window
  assign line_ofs = {1'b0, item_i.line} - {1'b0, top_line_q};
  assign row      = line_ofs[7:3];

  // classify the transaction
  always_comb begin
    keep            = 1'b0;
    q_cmd_o.kind    = tmlr_pkg::CMD_CHAR;
    q_cmd_o.addr    = item_i.address;
    q_cmd_o.data    = item_i.data;
    q_cmd_o.glyph   = line_ofs[2:0];
    unique case (item_i.func)
      tmlr_pkg::FUNC_CHAR: begin
        keep = ({1'b0, item_i.address} < 12'(tmlr_pkg::CELLS));
      end
      tmlr_pkg::FUNC_FONT: begin
        keep         = 1'b1;
        q_cmd_o.kind = tmlr_pkg::CMD_FONT;
      end
      tmlr_pkg::FUNC_LINE: begin
        keep         = !line_ofs[8] && (line_ofs < 9'(tmlr_pkg::LINES));
        q_cmd_o.kind = tmlr_pkg::CMD_LINE;
        q_cmd_o.addr = tmlr_pkg::FONT_AW'(tmlr_pkg::TXT_AW'(row * tmlr_pkg::COLUMNS));
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // input handshake
  assign item_i.ready = init_done_i && !q_full_i;
  assign q_push_o     = item_i.valid && item_i.ready && keep;

endmodule

FILE: rtl/tmlr_queue.sv
// ----------------------------------------------------------------------------
// tmlr_queue: command queue
// Short FIFO of commands between the front end and the back end so that
// each side stalls on its own.
// ----------------------------------------------------------------------------
module tmlr_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tmlr_pkg::cmd_t       cmd_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output tmlr_pkg::cmd_t       cmd_o
);

  tmlr_pkg::cmd_t                  entry_q [tmlr_pkg::QDEPTH];
  logic [tmlr_pkg::QPTR_W-1:0]     wr_ptr_q;
  logic [tmlr_pkg::QPTR_W-1:0]     rd_ptr_q;
  logic [tmlr_pkg::QCNT_W-1:0]     cnt_q;

  assign full_o  = (cnt_q == tmlr_pkg::QCNT_W'(tmlr_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/tmlr_back.sv
// ----------------------------------------------------------------------------
// tmlr_back: execution back end
// Owns the character and font stores, clears the character store after
// reset, executes write commands and streams rendered cells through a
// two-read pipeline into a small result buffer.
// ----------------------------------------------------------------------------
module tmlr_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  tmlr_pkg::cmd_t       q_cmd_i,
  output logic                 q_pop_o,
  output logic                 init_done_o,
  tmlr_result_if.source        result_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_CMD,
    ST_LINE
  } state_e;

  state_e                        state_q;
  logic [tmlr_pkg::TXT_AW-1:0]   clr_q;
  logic [tmlr_pkg::TXT_AW-1:0]   base_q;
  logic [2:0]                    glyph_q;
  logic [tmlr_pkg::COL_W-1:0]    col_q;

  // pipeline stage after the character read, and after the font read
  logic       s1_v_q, s1_last_q;
  logic [2:0] s1_glyph_q;
  logic       s2_v_q, s2_last_q, s2_inv_q;

  // result buffer
  logic [7:0]                  ob_pix_q  [tmlr_pkg::QDEPTH];
  logic                        ob_last_q [tmlr_pkg::QDEPTH];
  logic [tmlr_pkg::QPTR_W-1:0] ob_wr_q, ob_rd_q;
  logic [tmlr_pkg::QCNT_W-1:0] ob_cnt_q;
  logic [tmlr_pkg::QCNT_W-1:0] in_flight;

  logic                        issue, is_last, ob_pop;
  logic                        txt_we, txt_re;
  logic [tmlr_pkg::TXT_AW-1:0] txt_waddr, txt_raddr;
  logic [7:0]                  txt_wdata, txt_rdata;
  logic                        font_we;
  logic [7:0]                  font_rdata;
  logic [tmlr_pkg::FONT_AW-1:0] font_raddr;

  // pop commands only while idle
  assign init_done_o = (state_q != ST_CLEAR);
  assign q_pop_o     = (state_q == ST_CMD) && q_valid_i;

  // issue one cell per cycle while the result buffer has room for it
  assign in_flight = ob_cnt_q + tmlr_pkg::QCNT_W'(s1_v_q) + tmlr_pkg::QCNT_W'(s2_v_q);
  assign issue     = (state_q == ST_LINE) &&
                     (in_flight < tmlr_pkg::QCNT_W'(tmlr_pkg::QDEPTH));
  assign is_last   = (col_q == tmlr_pkg::COL_W'(tmlr_pkg::COLUMNS - 1));

  // character store ports
  always_comb begin
    txt_we    = 1'b0;
    txt_waddr = q_cmd_i.addr[tmlr_pkg::TXT_AW-1:0];
    txt_wdata = q_cmd_i.data;
    if (state_q == ST_CLEAR) begin
      txt_we    = 1'b1;
      txt_waddr = clr_q;
      txt_wdata = '0;
    end else if (q_pop_o && (q_cmd_i.kind == tmlr_pkg::CMD_CHAR)) begin
      txt_we = 1'b1;
    end
  end

  assign txt_re    = issue;
  assign txt_raddr = base_q + tmlr_pkg::TXT_AW'(col_q);

  tmlr_ram #(
    .WIDTH (8),
    .DEPTH (tmlr_pkg::CELLS)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (txt_we),
    .waddr_i (txt_waddr),
    .wdata_i (txt_wdata),
    .re_i    (txt_re),
    .raddr_i (txt_raddr),
    .rdata_o (txt_rdata)
  );

  // font store ports
  assign font_we    = q_pop_o && (q_cmd_i.kind == tmlr_pkg::CMD_FONT);
  assign font_raddr = {txt_rdata, s1_glyph_q};

  tmlr_ram #(
    .WIDTH (8),
    .DEPTH (tmlr_pkg::FONT_DEPTH)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (font_we),
    .waddr_i (q_cmd_i.addr),
    .wdata_i (q_cmd_i.data),
    .re_i    (s1_v_q),
    .raddr_i (font_raddr),
    .rdata_o (font_rdata)
  );

  // sequencer: clearing pass, command dispatch and cell issue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      base_q  <= '0;
      glyph_q <= '0;
      col_q   <= '0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == tmlr_pkg::TXT_AW'(tmlr_pkg::CELLS - 1)) begin
            state_q <= ST_CMD;
          end
        end
        ST_CMD: begin
          if (q_pop_o && (q_cmd_i.kind == tmlr_pkg::CMD_LINE)) begin
            base_q  <= q_cmd_i.addr[tmlr_pkg::TXT_AW-1:0];
            glyph_q <= q_cmd_i.glyph;
            col_q   <= '0;
            state_q <= ST_LINE;
          end
        end
        ST_LINE: begin
          if (issue) begin
            col_q <= col_q + 1'b1;
            if (is_last) begin
              state_q <= ST_CMD;
            end
          end
        end
        default: begin
          state_q <= ST_CMD;
        end
      endcase
    end
  end

  // read pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
    end
  end

  // read pipeline payload
  always_ff @(posedge clk_i) begin
    s1_last_q  <= is_last;
    s1_glyph_q <= glyph_q;
    s2_last_q  <= s1_last_q;
    s2_inv_q   <= !txt_rdata[7];
  end

  // result buffer
  assign ob_pop = result_o.valid && result_o.ready;

  always_ff @(posedge clk_i) begin
    if (s2_v_q) begin
      ob_pix_q[ob_wr_q]  <= s2_inv_q ? ~font_rdata : font_rdata;
      ob_last_q[ob_wr_q] <= s2_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_wr_q  <= '0;
      ob_rd_q  <= '0;
      ob_cnt_q <= '0;
    end else begin
      if (s2_v_q) begin
        ob_wr_q <= ob_wr_q + 1'b1;
      end
      if (ob_pop) begin
        ob_rd_q <= ob_rd_q + 1'b1;
      end
      if (s2_v_q && !ob_pop) begin
        ob_cnt_q <= ob_cnt_q + 1'b1;
      end else if (ob_pop && !s2_v_q) begin
        ob_cnt_q <= ob_cnt_q - 1'b1;
      end
    end
  end

  assign result_o.valid  = (ob_cnt_q != '0);
  assign result_o.pixels = ob_pix_q[ob_rd_q];
  assign result_o.last   = ob_last_q[ob_rd_q];

endmodule

FILE: rtl/text_mode_line_renderer.sv
// ----------------------------------------------------------------------------
// text_mode_line_renderer: 8x8 text-mode character generator
// Character store, font store and scan line renderer with a front end,
// command queue and back end.
// ----------------------------------------------------------------------------
// After reset the block clears its 960-cell character store, one cell per
// clock, so it takes no input transaction until this pass is done
// (configuration writes are taken throughout). Character and font write
// transactions are executed as the back end pops them. A render
// transaction for a visible scan line gives 40 result transactions, one
// pixel byte per cell, at one per clock once the pipeline is running and
// while the result side takes them; each cell passes the character store
// read and then the font store read, and the back end pops no command
// until it has issued the last cell of the line. Lines outside the 192-line
// window, character writes beyond the last cell and unused function codes
// are accepted and give nothing. The font store is not cleared; render
// only glyphs whose font bytes have been written.
module text_mode_line_renderer (
  input  logic           clk_i,
  input  logic           rst_ni,
  tmlr_item_if.sink      item_i,
  tmlr_cfg_if.sink       cfg_i,
  tmlr_result_if.source  result_o
);

  logic           init_done;
  logic           q_full, q_push, q_pop, q_valid;
  tmlr_pkg::cmd_t cmd_in, cmd_out;

  // accept and classify
  tmlr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_i       (cfg_i),
    .init_done_i (init_done),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (cmd_in)
  );

  // command queue
  tmlr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (cmd_out)
  );

  // execute and render
  tmlr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (cmd_out),
    .q_pop_o     (q_pop),
    .init_done_o (init_done),
    .result_o    (result_o)
  );

endmodule
